// ----- hw/rtl/button_debounce_autorepeat_assert.svh -----
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_assert.svh
// Assertion macros used by the button debounce RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BDAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button debounce: same-cycle check failed");

// next-cycle implication, checked out of reset
`define BDAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button debounce: next-cycle check failed");

`endif

// ----- hw/rtl/bdar_pkg.sv -----
// ----------------------------------------------------------------------------
// bdar_pkg
// Types and constants for the button debounce with autorepeat.
// ----------------------------------------------------------------------------
`default_nettype none

package bdar_pkg;

    localparam int unsigned TIME_W   = 16;
    localparam int unsigned PIN_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic LEVEL_HIGH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PULL_UP_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_RATE_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIN_NUMBER      = 3'd4;

    localparam logic [TIME_W-1:0] RST_DEBOUNCE_MS     = 16'd50;
    localparam logic [TIME_W-1:0] RST_REPEAT_DELAY_MS = 16'd500;
    localparam logic [TIME_W-1:0] RST_REPEAT_RATE_MS  = 16'd100;

    typedef enum logic [1:0] {
        EV_RELEASED   = 2'd0,
        EV_PRESSED    = 2'd1,
        EV_AUTOREPEAT = 2'd2
    } t_event_kind;

    typedef enum logic [3:0] {
        PH_RELEASED   = 4'b0001,
        PH_TRACKING   = 4'b0010,
        PH_PRESSED    = 4'b0100,
        PH_AUTOREPEAT = 4'b1000
    } t_phase;

    typedef struct packed {
        logic              pin_level;
        logic [TIME_W-1:0] elapsed_ms;
    } t_in_item;

    typedef struct packed {
        t_event_kind      event_kind;
        logic [PIN_W-1:0] event_pin;
    } t_out_item;

    typedef struct packed {
        logic              pull_up_mode;
        logic [TIME_W-1:0] debounce_ms;
        logic [TIME_W-1:0] repeat_delay_ms;
        logic [TIME_W-1:0] repeat_rate_ms;
        logic [PIN_W-1:0]  pin_number;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic              last_pressed;
        logic [TIME_W-1:0] countdown;
        t_event_kind       last_event;
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/bdar_tracker.sv -----
// ----------------------------------------------------------------------------
// bdar_tracker
// Next-state and event logic for one update tick.
// ----------------------------------------------------------------------------
`default_nettype none

module bdar_tracker
    import bdar_pkg::*;
(
    input  var t_state    i_state,
    input  var t_cfg      i_cfg,
    input  var t_in_item  i_item,
    output var t_state    o_state,
    output logic          o_emit,
    output var t_out_item o_result
);

    logic        w_pressed;
    logic        w_raise;
    t_event_kind w_kind;

    assign w_pressed = i_cfg.pull_up_mode ? (i_item.pin_level != LEVEL_HIGH)
                                          : (i_item.pin_level == LEVEL_HIGH);

    always_comb begin
        o_state = i_state;
        w_raise = 1'b0;
        w_kind  = EV_RELEASED;
        if (w_pressed != i_state.last_pressed) begin
            o_state.last_pressed = w_pressed;
            if (w_pressed) begin
                o_state.countdown = i_cfg.debounce_ms;
                o_state.phase     = PH_TRACKING;
            end else begin
                o_state.phase = PH_RELEASED;
                w_raise       = 1'b1;
                w_kind        = EV_RELEASED;
            end
        end else if (i_state.phase != PH_RELEASED) begin
            if (i_item.elapsed_ms < i_state.countdown) begin
                o_state.countdown = i_state.countdown - i_item.elapsed_ms;
            end else if (i_state.phase == PH_TRACKING) begin
                o_state.phase     = PH_PRESSED;
                o_state.countdown = i_cfg.repeat_delay_ms;
                w_raise           = 1'b1;
                w_kind            = EV_PRESSED;
            end else begin
                o_state.phase     = PH_AUTOREPEAT;
                o_state.countdown = i_cfg.repeat_rate_ms;
                w_raise           = 1'b1;
                w_kind            = w_pressed ? EV_AUTOREPEAT : EV_RELEASED;
            end
        end
        o_emit = w_raise && (w_kind != i_state.last_event);
        if (o_emit) begin
            o_state.last_event = w_kind;
        end
    end

    assign o_result.event_kind = w_kind;
    assign o_result.event_pin  = i_cfg.pin_number;

endmodule

`default_nettype wire

// ----- hw/rtl/button_debounce_autorepeat.sv -----
// ----------------------------------------------------------------------------
// button_debounce_autorepeat
// Debounces one button from periodic ticks and raises pressed, autorepeat
// and released events.
// ----------------------------------------------------------------------------
// Result path: a transferred tick is held in the input register; its event
//   then goes to the result register, or to the skid entry if that is full.
// Throughput: one tick per cycle while the skid entry is empty; a two-entry
//   result buffer keeps input moving while a result waits on the output.
// Reset: synchronous, active low; clears the tracker state, the buffers and
//   loads the register defaults (0, 50, 500, 100, 0).
`default_nettype none

module button_debounce_autorepeat
    import bdar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  var t_in_item          i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output var t_out_item         o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "button_debounce_autorepeat_assert.svh"

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_data;
    t_out_item n_out_data;
    logic      r_skid_valid;
    logic      n_skid_valid;
    t_out_item r_skid_data;
    t_out_item n_skid_data;

    logic      w_proc;
    logic      w_take;
    logic      w_emit;
    t_state    w_state;
    t_out_item w_result;

    bdar_tracker u_tracker (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_data),
        .o_state  (w_state),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    assign o_in_stall  = r_in_valid && r_skid_valid;
    assign w_proc      = r_in_valid && !r_skid_valid;
    assign w_take      = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state      = w_proc ? w_state : r_state;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (w_proc && w_emit) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out_data  = w_result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = w_result;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pull_up_mode    <= 1'b0;
            r_cfg.debounce_ms     <= RST_DEBOUNCE_MS;
            r_cfg.repeat_delay_ms <= RST_REPEAT_DELAY_MS;
            r_cfg.repeat_rate_ms  <= RST_REPEAT_RATE_MS;
            r_cfg.pin_number      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PULL_UP_MODE:    r_cfg.pull_up_mode    <= i_cfg_data[0];
                CFG_DEBOUNCE_MS:     r_cfg.debounce_ms     <= i_cfg_data[TIME_W-1:0];
                CFG_REPEAT_DELAY_MS: r_cfg.repeat_delay_ms <= i_cfg_data[TIME_W-1:0];
                CFG_REPEAT_RATE_MS:  r_cfg.repeat_rate_ms  <= i_cfg_data[TIME_W-1:0];
                CFG_PIN_NUMBER:      r_cfg.pin_number      <= i_cfg_data[PIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_RELEASED;
            r_state.last_pressed <= 1'b0;
            r_state.countdown    <= '0;
            r_state.last_event   <= EV_RELEASED;
            r_in_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_skid_valid         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_data <= i_in_data;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    `BDAR_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `BDAR_ASSERT_IMPL(a_emit_is_new, i_clk, i_rst_n, w_proc && w_emit,
        w_result.event_kind != r_state.last_event)
    `BDAR_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && !i_out_stall,
        !r_skid_valid && r_out_valid)
    `BDAR_ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !w_proc, $stable(r_state))

endmodule

`default_nettype wire

// ----- tb/sv/button_debounce_autorepeat_checker.sv -----
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_checker
// Watches the tick, event and register ports of the debouncer, keeps its own
// copy of the tracker state and settings, and checks every event transfer
// in order against the predicted event stream.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_autorepeat_checker
    import bdar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  var t_in_item          i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  var t_out_item         i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_ticks,
    output int                    o_events
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg              settings;
    t_phase            btn_phase;
    logic              btn_held;
    logic [TIME_W-1:0] btn_remain;
    t_event_kind       last_sent;
    t_out_item         events_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_ticks      = 0;
        o_events     = 0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        o_fail_count++;
    endtask

    task automatic raise_event(input t_event_kind kind);
        t_out_item ev;
        if (kind != last_sent) begin
            last_sent     = kind;
            ev.event_kind = kind;
            ev.event_pin  = settings.pin_number;
            events_due.push_back(ev);
        end
    endtask

    task automatic track_tick(input t_in_item tick);
        logic pressed;
        if (settings.pull_up_mode) begin
            pressed = (tick.pin_level != LEVEL_HIGH);
        end else begin
            pressed = (tick.pin_level == LEVEL_HIGH);
        end
        if (pressed != btn_held) begin
            btn_held = pressed;
            if (pressed) begin
                btn_remain = settings.debounce_ms;
                btn_phase  = PH_TRACKING;
            end else begin
                btn_phase = PH_RELEASED;
                raise_event(EV_RELEASED);
            end
        end else if (btn_phase != PH_RELEASED) begin
            if (tick.elapsed_ms < btn_remain) begin
                btn_remain = btn_remain - tick.elapsed_ms;
            end else if (btn_phase == PH_TRACKING) begin
                btn_phase  = PH_PRESSED;
                btn_remain = settings.repeat_delay_ms;
                raise_event(EV_PRESSED);
            end else begin
                btn_phase  = PH_AUTOREPEAT;
                btn_remain = settings.repeat_rate_ms;
                raise_event(pressed ? EV_AUTOREPEAT : EV_RELEASED);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            settings.pull_up_mode    = 1'b0;
            settings.debounce_ms     = RST_DEBOUNCE_MS;
            settings.repeat_delay_ms = RST_REPEAT_DELAY_MS;
            settings.repeat_rate_ms  = RST_REPEAT_RATE_MS;
            settings.pin_number      = '0;
            btn_phase  = PH_RELEASED;
            btn_held   = 1'b0;
            btn_remain = '0;
            last_sent  = EV_RELEASED;
            events_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PULL_UP_MODE:    settings.pull_up_mode    = i_cfg_data[0];
                    CFG_DEBOUNCE_MS:     settings.debounce_ms     = i_cfg_data;
                    CFG_REPEAT_DELAY_MS: settings.repeat_delay_ms = i_cfg_data;
                    CFG_REPEAT_RATE_MS:  settings.repeat_rate_ms  = i_cfg_data;
                    CFG_PIN_NUMBER:      settings.pin_number      = i_cfg_data[PIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                track_tick(i_in_data);
                o_ticks++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (events_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected event kind %0d pin %0d",
                        i_out_data.event_kind, i_out_data.event_pin));
                end else begin
                    want = events_due.pop_front();
                    o_events++;
                    if (i_out_data.event_kind !== want.event_kind) begin
                        report_mismatch($sformatf("event kind %0d, expected %0d",
                            i_out_data.event_kind, want.event_kind));
                    end
                    if (i_out_data.event_pin !== want.event_pin) begin
                        report_mismatch($sformatf("event pin %0d, expected %0d",
                            i_out_data.event_pin, want.event_pin));
                    end
                end
            end
        end
        o_pending = events_due.size();
    end

endmodule

`default_nettype wire

// ----- tb/sv/button_debounce_autorepeat_tb.sv -----
// ----------------------------------------------------------------------------
// button_debounce_autorepeat_tb
// Drives update ticks and register writes into the button debouncer: a
// directed pass over countdown expiry, zero times, duplicate events and a
// polarity change, then random press and bounce sequences under several
// settings with bursty ticks and a stalling event receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_autorepeat_tb
    import bdar_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TICKS = 600;
    localparam int NUM_PHASES   = 6;
    localparam int DRAIN_CYCLES = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int ticks_seen;
    int events_seen;
    int burst_left = 0;
    int settings_used = 1;

    logic [6:0]  stall_step = '0;
    logic [15:0] stall_pat = '0;

    always #1 clk = ~clk;

    button_debounce_autorepeat u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    button_debounce_autorepeat_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_ticks      (ticks_seen),
        .o_events     (events_seen)
    );

    always @(negedge clk) begin
        stall_step <= stall_step + 7'd1;
        if (stall_step == '0) begin
            stall_pat <= ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
        end
        out_stall <= stall_pat[stall_step[3:0]];
    end

    // enter and leave at a falling edge
    task automatic send_tick(input logic level, input logic [TIME_W-1:0] dt);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid           <= 1'b1;
        in_data.pin_level  <= level;
        in_data.elapsed_ms <= dt;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_settings(input t_cfg s, input logic [4:0] mask);
        logic [CFG_DATA_W-1:0] value;
        for (int idx = 0; idx < 5; idx++) begin
            if (mask[idx]) begin
                case (CFG_IDX_W'(idx))
                    CFG_PULL_UP_MODE:    value = CFG_DATA_W'(s.pull_up_mode);
                    CFG_DEBOUNCE_MS:     value = s.debounce_ms;
                    CFG_REPEAT_DELAY_MS: value = s.repeat_delay_ms;
                    CFG_REPEAT_RATE_MS:  value = s.repeat_rate_ms;
                    default:             value = CFG_DATA_W'(s.pin_number);
                endcase
                cfg_we    <= 1'b1;
                cfg_index <= CFG_IDX_W'(idx);
                cfg_data  <= value;
                @(negedge clk);
            end
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        t_cfg s;
        int   scale;
        int   sent;
        int   hold;
        logic press_lvl;
        logic lvl;
        logic [TIME_W-1:0] dt;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default settings: debounce, delay expiry, duplicate autorepeat, release
        send_tick(1'b0, 16'd0);
        send_tick(1'b1, 16'd10);
        send_tick(1'b1, 16'd20);
        send_tick(1'b1, 16'd30);
        send_tick(1'b1, 16'd499);
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b1, 16'd100);
        send_tick(1'b0, 16'd0);
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b1, 16'd5);
        send_tick(1'b0, 16'd5);
        settle();

        // pull-up polarity with all times zero
        s.pull_up_mode    = 1'b1;
        s.debounce_ms     = '0;
        s.repeat_delay_ms = '0;
        s.repeat_rate_ms  = '0;
        s.pin_number      = 8'hFF;
        write_settings(s, 5'b11111);
        send_tick(1'b0, 16'd0);
        send_tick(1'b0, 16'd0);
        send_tick(1'b0, 16'd0);
        send_tick(1'b0, 16'd0);
        send_tick(1'b1, 16'd0);
        send_tick(1'b0, 16'd7);
        send_tick(1'b0, 16'd1);
        settle();

        // flip polarity while held
        s.pull_up_mode = 1'b0;
        write_settings(s, 5'b00001);
        send_tick(1'b0, 16'd3);
        send_tick(1'b1, 16'd0);
        send_tick(1'b1, 16'd0);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 0) begin
                s = '0;
            end else if (p == 1) begin
                s.pull_up_mode    = 1'b1;
                s.debounce_ms     = 16'hFFFF;
                s.repeat_delay_ms = 16'hFFFF;
                s.repeat_rate_ms  = 16'hFFFF;
                s.pin_number      = 8'h81;
            end else begin
                s.pull_up_mode    = 1'($urandom_range(0, 1));
                s.debounce_ms     = 16'($urandom_range(0, 200));
                s.repeat_delay_ms = 16'($urandom_range(0, 400));
                s.repeat_rate_ms  = 16'($urandom_range(0, 150));
                s.pin_number      = 8'($urandom);
            end
            write_settings(s, 5'b11111);
            scale = s.debounce_ms;
            if (s.repeat_delay_ms > scale) scale = s.repeat_delay_ms;
            if (s.repeat_rate_ms > scale) scale = s.repeat_rate_ms;
            scale = scale / 3 + 1;
            press_lvl = ~s.pull_up_mode;
            sent = 0;
            while (sent < RANDOM_TICKS / NUM_PHASES) begin
                hold = $urandom_range(1, 12);
                for (int k = 0; k < hold + $urandom_range(1, 3); k++) begin
                    lvl = (k < hold) ? press_lvl : ~press_lvl;
                    if ($urandom_range(0, 5) == 0) lvl = ~lvl;
                    if ($urandom_range(0, 7) == 0) begin
                        dt = 16'($urandom);
                    end else begin
                        dt = 16'($urandom_range(0, scale));
                    end
                    send_tick(lvl, dt);
                    sent++;
                end
            end
            settle();
        end

        $display("Ran %0d ticks under %0d register settings, %0d events checked in order",
            ticks_seen, settings_used, events_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d events outstanding", pending);
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
